[rtl/core/spq_pkg.sv]
// spq_pkg: request, status, state and op codes shared by the sorted priority queue
// also the command and status structs between the controller and the datapath
// no dependencies
package spq_pkg;

	// request codes on req_type
	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_POP    = 2'd1,
		REQ_PEEK   = 2'd2
	} req_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} st_t;

	// controller states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// datapath operations chosen by the controller
	typedef enum logic [2:0] {
		OP_NOP    = 3'd0,
		OP_INSERT = 3'd1,
		OP_POP    = 3'd2,
		OP_PEEK   = 3'd3,
		OP_FULL   = 3'd4,
		OP_EMPTY  = 3'd5
	} op_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic exec;
		op_t  op;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] req;
		logic       empty;
		logic       full;
	} dp_stat_t;

endpackage

[rtl/core/spq_ctrl.sv]
// spq_ctrl: controller state machine of the sorted priority queue
// picks the datapath operation from the latched request and the fill status
// depends on spq_pkg
module spq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	input  spq_pkg::dp_stat_t dp_stat,
	output spq_pkg::dp_cmd_t  dp_cmd
);

	spq_pkg::state_t state_q;
	spq_pkg::state_t state_nxt;
	logic            done_q;

	// state register and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == spq_pkg::S_EXEC);
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			spq_pkg::S_IDLE: begin
				if (start) state_nxt = spq_pkg::S_EXEC;
			end
			spq_pkg::S_EXEC: begin
				state_nxt = spq_pkg::S_IDLE;
			end
			default: state_nxt = spq_pkg::S_IDLE;
		endcase
	end

	// outputs and operation decode
	always_comb begin
		dp_cmd.latch = 1'b0;
		dp_cmd.exec  = 1'b0;
		dp_cmd.op    = spq_pkg::OP_NOP;
		busy         = 1'b0;
		unique case (state_q)
			spq_pkg::S_IDLE: begin
				dp_cmd.latch = start;
			end
			spq_pkg::S_EXEC: begin
				busy        = 1'b1;
				dp_cmd.exec = 1'b1;
				unique case (dp_stat.req)
					spq_pkg::REQ_INSERT:
						dp_cmd.op = dp_stat.full ? spq_pkg::OP_FULL : spq_pkg::OP_INSERT;
					spq_pkg::REQ_POP:
						dp_cmd.op = dp_stat.empty ? spq_pkg::OP_EMPTY : spq_pkg::OP_POP;
					spq_pkg::REQ_PEEK:
						dp_cmd.op = dp_stat.empty ? spq_pkg::OP_EMPTY : spq_pkg::OP_PEEK;
					default:
						dp_cmd.op = spq_pkg::OP_NOP;
				endcase
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	assign done = done_q;

endmodule

[rtl/core/spq_datapath.sv]
// spq_datapath: shifting sorted register array, request latch and result registers
// every entry compares its key with the new one in parallel and the whole array shifts at once
// depends on spq_pkg
module spq_datapath #(
	parameter int QUEUE_DEPTH = 16,
	parameter int KEY_WIDTH   = 16,
	parameter int REF_WIDTH   = 32,
	parameter int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  spq_pkg::dp_cmd_t      dp_cmd,
	output spq_pkg::dp_stat_t     dp_stat,
	input  logic [1:0]            req_type,
	input  logic [KEY_WIDTH-1:0]  item_key,
	input  logic [REF_WIDTH-1:0]  item_ref,
	output logic [REF_WIDTH-1:0]  out_ref,
	output logic [KEY_WIDTH-1:0]  out_key,
	output logic [1:0]            status,
	output logic [CNT_WIDTH-1:0]  occupancy
);

	logic [1:0]           req_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [REF_WIDTH-1:0] ref_q;
	logic [CNT_WIDTH-1:0] count_q;
	logic [KEY_WIDTH-1:0] keys_q [QUEUE_DEPTH];
	logic [REF_WIDTH-1:0] refs_q [QUEUE_DEPTH];
	logic [REF_WIDTH-1:0] out_ref_q;
	logic [KEY_WIDTH-1:0] out_key_q;
	spq_pkg::st_t         status_q;
	logic [QUEUE_DEPTH-1:0] gt;

	// request latch on the accepted beat
	always_ff @(posedge clk) begin
		if (dp_cmd.latch) begin
			req_q <= req_type;
			key_q <= item_key;
			ref_q <= item_ref;
		end
	end

	// per-entry compare: stored and strictly greater than the new key
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			gt[i] = (CNT_WIDTH'(i) < count_q) && (keys_q[i] > key_q);
		end
	end

	// entry array: shift up around the insert point, or shift down on pop
	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_entry
		always_ff @(posedge clk) begin
			if (dp_cmd.exec && dp_cmd.op == spq_pkg::OP_INSERT) begin
				if (g > 0 && gt[(g > 0) ? g - 1 : 0]) begin
					keys_q[g] <= keys_q[(g > 0) ? g - 1 : 0];
					refs_q[g] <= refs_q[(g > 0) ? g - 1 : 0];
				end else if (gt[g] || CNT_WIDTH'(g) == count_q) begin
					keys_q[g] <= key_q;
					refs_q[g] <= ref_q;
				end
			end else if (dp_cmd.exec && dp_cmd.op == spq_pkg::OP_POP) begin
				if (g < QUEUE_DEPTH - 1) begin
					keys_q[g] <= keys_q[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
					refs_q[g] <= refs_q[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
				end
			end
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (dp_cmd.exec) begin
			case (dp_cmd.op)
				spq_pkg::OP_INSERT: count_q <= count_q + CNT_WIDTH'(1);
				spq_pkg::OP_POP:    count_q <= count_q - CNT_WIDTH'(1);
				default:            count_q <= count_q;
			endcase
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (dp_cmd.exec) begin
			case (dp_cmd.op)
				spq_pkg::OP_POP, spq_pkg::OP_PEEK: begin
					out_key_q <= keys_q[0];
					out_ref_q <= refs_q[0];
					status_q  <= spq_pkg::ST_OK;
				end
				spq_pkg::OP_FULL: begin
					out_key_q <= '0;
					out_ref_q <= '0;
					status_q  <= spq_pkg::ST_FULL;
				end
				spq_pkg::OP_EMPTY: begin
					out_key_q <= '0;
					out_ref_q <= '0;
					status_q  <= spq_pkg::ST_EMPTY;
				end
				default: begin
					out_key_q <= '0;
					out_ref_q <= '0;
					status_q  <= spq_pkg::ST_OK;
				end
			endcase
		end
	end

	assign dp_stat.req   = req_q;
	assign dp_stat.empty = (count_q == '0);
	assign dp_stat.full  = (count_q == CNT_WIDTH'(QUEUE_DEPTH));

	assign out_ref   = out_ref_q;
	assign out_key   = out_key_q;
	assign status    = status_q;
	assign occupancy = count_q;

endmodule

[rtl/core/sorted_priority_queue.sv]
// sorted_priority_queue: top level, controller plus sorted register array datapath
// depends on spq_pkg, spq_ctrl, spq_datapath
//
// usage
// a request beat is taken at a rising edge with start high and busy low:
// req_type 0 inserts item_key/item_ref, 1 pops the least key, 2 peeks at it.
// equal keys leave in arrival order. each request gives one result beat on
// out_ref, out_key, status and occupancy, marked by done for one cycle.
// status 1 reports pop or peek on an empty queue, 2 an insert dropped because
// the queue holds QUEUE_DEPTH entries; occupancy is the count after the request.
// busy is high after accept while the array compares all entries in parallel
// and shifts; done follows in the next cycle, and a new request can be taken
// in the done cycle. the receiver cannot stall: done is a strobe, and the result
// holds only until the next request executes. reset clears the fill count and
// the controller; the queue comes up empty.
module sorted_priority_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int KEY_WIDTH   = 16,
	parameter int REF_WIDTH   = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           req_type,
	input  logic [KEY_WIDTH-1:0]                 item_key,
	input  logic [REF_WIDTH-1:0]                 item_ref,
	output logic                                 done,
	output logic [REF_WIDTH-1:0]                 out_ref,
	output logic [KEY_WIDTH-1:0]                 out_key,
	output logic [1:0]                           status,
	output logic [$clog2(QUEUE_DEPTH + 1)-1:0]   occupancy
);

	localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);

	spq_pkg::dp_cmd_t  dp_cmd;
	spq_pkg::dp_stat_t dp_stat;

	// controller
	spq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.done    (done),
		.dp_stat (dp_stat),
		.dp_cmd  (dp_cmd)
	);

	// datapath
	spq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.KEY_WIDTH   (KEY_WIDTH),
		.REF_WIDTH   (REF_WIDTH),
		.CNT_WIDTH   (CntWidth)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.dp_cmd    (dp_cmd),
		.dp_stat   (dp_stat),
		.req_type  (req_type),
		.item_key  (item_key),
		.item_ref  (item_ref),
		.out_ref   (out_ref),
		.out_key   (out_key),
		.status    (status),
		.occupancy (occupancy)
	);

endmodule

[rtl/core/spq_checker.sv]
// spq_checker: port-level assertions for the sorted priority queue
// bound to sorted_priority_queue; depends on spq_pkg
module spq_checker #(
	parameter int QUEUE_DEPTH = 16,
	parameter int KEY_WIDTH   = 16,
	parameter int REF_WIDTH   = 32
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               done,
	input logic [REF_WIDTH-1:0]               out_ref,
	input logic [KEY_WIDTH-1:0]               out_key,
	input logic [1:0]                         status,
	input logic [$clog2(QUEUE_DEPTH + 1)-1:0] occupancy
);

	// an accepted beat makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	// each request produces exactly one result beat right after busy
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("result beat missing after busy cycle");

	a_done_only_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a request");

	// a full status comes with a full queue
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == spq_pkg::ST_FULL |->
			occupancy == ($clog2(QUEUE_DEPTH + 1))'(QUEUE_DEPTH))
		else $error("full status with queue not full");

	// an empty report carries no entry
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == spq_pkg::ST_EMPTY |->
			occupancy == '0 && out_key == '0 && out_ref == '0)
		else $error("empty status with data or entries");

endmodule

bind sorted_priority_queue spq_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH),
	.KEY_WIDTH   (KEY_WIDTH),
	.REF_WIDTH   (REF_WIDTH)
) u_spq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.out_ref   (out_ref),
	.out_key   (out_key),
	.status    (status),
	.occupancy (occupancy)
);
